FILE: design/pcd_pkg.sv
// Shared types, constants and spline tables for the charge deposition core.
`default_nettype none

package pcd_pkg;

  localparam int unsigned MAX_DIM   = 16;
  localparam int unsigned MAX_ORDER = 5;
  localparam int unsigned DIM_AW    = 4;
  localparam int unsigned CELL_AW   = 3 * DIM_AW;
  localparam int unsigned CELL_W    = 48;
  localparam int unsigned CELLS     = MAX_DIM * MAX_DIM * MAX_DIM;

  localparam logic [30:0] W_ONE  = 31'h4000_0000;
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_AX_MUL,
    S_AX_BASE,
    S_AX_MOD,
    S_AX_PW,
    S_AX_PWW,
    S_AX_NUM,
    S_AX_DIV,
    S_AX_WT,
    S_C_ZY,
    S_C_ZYW,
    S_C_W3,
    S_C_Q,
    S_C_WR,
    S_RD,
    S_RD_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_DEPOSIT = 2'd0,
    OP_READ    = 2'd1,
    OP_WRITE   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_ORDER = 3'd0,
    CFG_DIM_Z = 3'd1,
    CFG_DIM_Y = 3'd2,
    CFG_DIM_X = 3'd3,
    CFG_INV_Z = 3'd4,
    CFG_INV_Y = 3'd5,
    CFG_INV_X = 3'd6
  } cfg_e;

  typedef struct packed {
    logic                we;
    logic [CELL_AW-1:0]  waddr;
    logic [CELL_W-1:0]   wdata;
    logic                re;
    logic [CELL_AW-1:0]  raddr;
  } grid_req_t;

  typedef struct packed {
    logic [2:0] sh;
    logic       div3;
  } den_t;

  // Spline polynomial coefficient for order index pi (order-2), point j, power k.
  function automatic logic signed [7:0] spline_coef(input logic [1:0] pi,
                                                    input logic [2:0] j,
                                                    input logic [2:0] k);
    logic signed [7:0] row [5];
    row = '{8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0};
    case ({pi, j})
      {2'd0, 3'd0}: row = '{8'sd1, -8'sd1, 8'sd0, 8'sd0, 8'sd0};
      {2'd0, 3'd1}: row = '{8'sd0, 8'sd1, 8'sd0, 8'sd0, 8'sd0};
      {2'd1, 3'd0}: row = '{8'sd1, -8'sd4, 8'sd4, 8'sd0, 8'sd0};
      {2'd1, 3'd1}: row = '{8'sd3, 8'sd0, -8'sd4, 8'sd0, 8'sd0};
      {2'd1, 3'd2}: row = '{8'sd1, 8'sd4, 8'sd4, 8'sd0, 8'sd0};
      {2'd2, 3'd0}: row = '{8'sd1, -8'sd6, 8'sd12, -8'sd8, 8'sd0};
      {2'd2, 3'd1}: row = '{8'sd23, -8'sd30, -8'sd12, 8'sd24, 8'sd0};
      {2'd2, 3'd2}: row = '{8'sd23, 8'sd30, -8'sd12, -8'sd24, 8'sd0};
      {2'd2, 3'd3}: row = '{8'sd1, 8'sd6, 8'sd12, 8'sd8, 8'sd0};
      {2'd3, 3'd0}: row = '{8'sd1, -8'sd8, 8'sd24, -8'sd32, 8'sd16};
      {2'd3, 3'd1}: row = '{8'sd19, -8'sd44, 8'sd24, 8'sd16, -8'sd16};
      {2'd3, 3'd2}: row = '{8'sd115, 8'sd0, -8'sd120, 8'sd0, 8'sd48};
      {2'd3, 3'd3}: row = '{8'sd19, 8'sd44, 8'sd24, -8'sd16, -8'sd16};
      {2'd3, 3'd4}: row = '{8'sd1, 8'sd8, 8'sd24, 8'sd32, 8'sd16};
      default:      row = '{8'sd0, 8'sd0, 8'sd0, 8'sd0, 8'sd0};
    endcase
    return (k > 3'd4) ? 8'sd0 : row[k];
  endfunction

  // Denominator as a shift plus an optional divide by 3.
  function automatic den_t spline_den(input logic [1:0] pi, input logic [2:0] j);
    den_t d;
    d = '{sh: 3'd0, div3: 1'b0};
    case (pi)
      2'd1: d = '{sh: (j == 3'd1) ? 3'd2 : 3'd3, div3: 1'b0};  // 8, 4, 8
      2'd2: d = '{sh: 3'd4, div3: 1'b1};                        // 48
      2'd3: begin
        case (j)
          3'd0, 3'd4: d = '{sh: 3'd7, div3: 1'b1};              // 384
          3'd2:       d = '{sh: 3'd6, div3: 1'b1};              // 192
          default:    d = '{sh: 3'd5, div3: 1'b1};              // 96
        endcase
      end
      default: d = '{sh: 3'd0, div3: 1'b0};
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: design/pcd_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
`default_nettype none

module pcd_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: design/pcd_grid.sv
// Charge grid store: one write port, one read port with registered data.
`default_nettype none

module pcd_grid (
  input  wire logic                  clk_i,
  input  wire pcd_pkg::grid_req_t    req_i,
  output logic [pcd_pkg::CELL_W-1:0] rdata_o
);

  logic [pcd_pkg::CELL_W-1:0] mem [pcd_pkg::CELLS];
  logic [pcd_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/particle_charge_deposition_core.sv
// Top level: sequencer and datapath for spline charge deposition on a 3D grid.
// Deposit: sequenced through the single shared multiplier and the one read-modify-write grid port.
// Read: grid read register, then the output register once any held result is taken; write:
//   stored in the cycle it is accepted. One item at a time.
// Reset: control and config registers return to reset values, then a clearing pass zeroes
//   all 4096 cells, one per cycle, with in_ready_o low; config writes still taken.
`default_nettype none

module particle_charge_deposition_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [23:0] cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [31:0] pos_z_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic signed [31:0] charge_i,
  input  wire logic [3:0]  cell_z_i,
  input  wire logic [3:0]  cell_y_i,
  input  wire logic [3:0]  cell_x_i,
  input  wire logic signed [47:0] cell_value_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [47:0] cell_value_out_o
);

  // ---------------------------------------------------------------- config
  logic [2:0]  order_q;
  logic [4:0]  dim_q [3];   // 0 z, 1 y, 2 x
  logic [23:0] inv_q [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 3'd2;
      dim_q   <= '{5'd16, 5'd16, 5'd16};
      inv_q   <= '{24'h010000, 24'h010000, 24'h010000};
    end else if (cfg_valid_i) begin
      case (pcd_pkg::cfg_e'(cfg_index_i))
        pcd_pkg::CFG_ORDER: order_q  <= cfg_data_i[2:0];
        pcd_pkg::CFG_DIM_Z: dim_q[0] <= cfg_data_i[4:0];
        pcd_pkg::CFG_DIM_Y: dim_q[1] <= cfg_data_i[4:0];
        pcd_pkg::CFG_DIM_X: dim_q[2] <= cfg_data_i[4:0];
        pcd_pkg::CFG_INV_Z: inv_q[0] <= cfg_data_i;
        pcd_pkg::CFG_INV_Y: inv_q[1] <= cfg_data_i;
        pcd_pkg::CFG_INV_X: inv_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  pcd_pkg::state_e state_q, state_d;

  logic [1:0]  axis_q;
  logic [2:0]  j_q, k_q, a_q, b_q, c_q;
  logic [4:0]  cnt_q;
  logic [23:0] base_q;
  logic [4:0]  rem_q;
  logic        x_neg_q;
  logic [29:0] ax_q;
  logic [29:0] pw_q [2:4];
  logic signed [40:0] num_q;
  logic [30:0] w_q   [3][5];
  logic [3:0]  idx_q [3][5];
  logic [31:0] pos_q [3];
  logic        q_neg_q;
  logic [31:0] q_mag_q;
  logic [30:0] wzy_q;
  logic [pcd_pkg::CELL_AW-1:0] addr_q;
  logic [pcd_pkg::CELL_AW-1:0] clr_q;
  logic        out_valid_q;
  logic [47:0] out_q;

  logic [63:0] mul_p;
  logic [31:0] mul_a, mul_b;
  logic [47:0] grid_rd;
  pcd_pkg::grid_req_t grid_req;

  logic in_acc;
  assign in_ready_o = (state_q == pcd_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------- derived config
  logic [2:0] p_ord, p_last;
  logic [1:0] p_idx, half;
  logic [4:0] dim_c;

  always_comb begin
    if (order_q < 3'd2) begin
      p_ord = 3'd2;
    end else if (order_q > 3'(pcd_pkg::MAX_ORDER)) begin
      p_ord = 3'(pcd_pkg::MAX_ORDER);
    end else begin
      p_ord = order_q;
    end
    p_last = p_ord - 3'd1;
    p_idx  = 2'(p_ord - 3'd2);
    half   = 2'(p_last >> 1);
    if (dim_q[axis_q] < 5'd2) begin
      dim_c = 5'd2;
    end else if (dim_q[axis_q] > 5'(pcd_pkg::MAX_DIM)) begin
      dim_c = 5'(pcd_pkg::MAX_DIM);
    end else begin
      dim_c = dim_q[axis_q];
    end
  end

  // ---------------------------------------------------------------- axis arithmetic
  // Scaled position Q24.32, with +0.5 for odd orders.
  logic [56:0] s_val;
  logic signed [31:0] x_val;
  logic [29:0] ax_val;

  always_comb begin
    s_val = {1'b0, mul_p[55:0]} + (p_ord[0] ? 57'h0_8000_0000 : 57'd0);
    x_val = $signed({2'b00, s_val[31:2]});
    if (p_ord != 3'd2) begin
      x_val = x_val - 32'sh2000_0000;
    end
    ax_val = x_val[31] ? 30'(-x_val) : x_val[29:0];
  end

  // One bit of base mod dim per cycle.
  logic [4:0] rem_sh, rem_n;
  assign rem_sh = {rem_q[3:0], base_q[23]};
  assign rem_n  = (rem_sh >= dim_c) ? rem_sh - dim_c : rem_sh;

  // Wrapped indices for the P points of this axis.
  logic [3:0] idx_n [5];
  always_comb begin
    logic [5:0] v0;
    logic [4:0] t;
    v0 = {1'b0, rem_q} + {1'b0, dim_c} - {4'b0, half};
    if (v0 >= {1'b0, dim_c}) begin
      v0 = v0 - {1'b0, dim_c};
    end
    idx_n[0] = v0[3:0];
    for (int i = 1; i < 5; i++) begin
      t = {1'b0, idx_n[i-1]} + 5'd1;
      idx_n[i] = (t == dim_c) ? 4'd0 : t[3:0];
    end
  end

  // Polynomial term MAC, one power per cycle.
  logic signed [31:0] term;
  logic signed [39:0] prod;
  logic signed [40:0] num_d;
  always_comb begin
    case (k_q)
      3'd0:    term = 32'sh4000_0000;
      3'd1:    term = $signed({2'b00, ax_q});
      3'd2,
      3'd3,
      3'd4:    term = $signed({2'b00, pw_q[k_q]});
      default: term = 32'sd0;
    endcase
    if (x_neg_q && k_q[0]) begin
      term = -term;
    end
    prod  = pcd_pkg::spline_coef(p_idx, j_q, k_q) * term;
    num_d = num_q + 41'(prod);
  end

  // Divide by denominator and clamp to [0, 1.0].
  pcd_pkg::den_t den;
  logic [39:0] q40;
  logic [30:0] w_fin, r3;
  always_comb begin
    den = pcd_pkg::spline_den(p_idx, j_q);
    q40 = num_q[39:0] >> den.sh;
    r3  = mul_p[63:33];
    if (num_q[40] || (num_q == 41'sd0)) begin
      w_fin = 31'd0;
    end else if (!den.div3) begin
      w_fin = (q40 > 40'(pcd_pkg::W_ONE)) ? pcd_pkg::W_ONE : q40[30:0];
    end else if (|q40[39:32]) begin
      w_fin = pcd_pkg::W_ONE;
    end else begin
      w_fin = (r3 > pcd_pkg::W_ONE) ? pcd_pkg::W_ONE : r3;
    end
  end

  // Saturating cell update.
  logic signed [48:0] add_s, sum_s;
  logic [47:0] sum_sat;
  always_comb begin
    add_s = $signed({17'd0, mul_p[61:30]});
    if (q_neg_q) begin
      add_s = -add_s;
    end
    sum_s = $signed({grid_rd[47], grid_rd}) + add_s;
    if (sum_s[48] != sum_s[47]) begin
      sum_sat = sum_s[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end else begin
      sum_sat = sum_s[47:0];
    end
  end

  logic [pcd_pkg::CELL_AW-1:0] cell_a;
  assign cell_a = {idx_q[0][a_q], idx_q[1][b_q], idx_q[2][c_q]};

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcd_pkg::S_CLEAR:   if (&clr_q) state_d = pcd_pkg::S_IDLE;
      pcd_pkg::S_IDLE: begin
        if (in_acc) begin
          case (pcd_pkg::op_e'(op_i))
            pcd_pkg::OP_DEPOSIT: state_d = pcd_pkg::S_AX_MUL;
            pcd_pkg::OP_READ:    state_d = pcd_pkg::S_RD;
            default:             state_d = pcd_pkg::S_IDLE;
          endcase
        end
      end
      pcd_pkg::S_AX_MUL:  state_d = pcd_pkg::S_AX_BASE;
      pcd_pkg::S_AX_BASE: state_d = pcd_pkg::S_AX_MOD;
      pcd_pkg::S_AX_MOD:  if (cnt_q == 5'd0) state_d = pcd_pkg::S_AX_PW;
      pcd_pkg::S_AX_PW:   state_d = pcd_pkg::S_AX_PWW;
      pcd_pkg::S_AX_PWW:  state_d = (k_q == 3'd4) ? pcd_pkg::S_AX_NUM : pcd_pkg::S_AX_PW;
      pcd_pkg::S_AX_NUM:  if (k_q == 3'd4) state_d = pcd_pkg::S_AX_DIV;
      pcd_pkg::S_AX_DIV:  state_d = pcd_pkg::S_AX_WT;
      pcd_pkg::S_AX_WT: begin
        if (j_q != p_last) begin
          state_d = pcd_pkg::S_AX_NUM;
        end else begin
          state_d = (axis_q == 2'd2) ? pcd_pkg::S_C_ZY : pcd_pkg::S_AX_MUL;
        end
      end
      pcd_pkg::S_C_ZY:    state_d = pcd_pkg::S_C_ZYW;
      pcd_pkg::S_C_ZYW:   state_d = pcd_pkg::S_C_W3;
      pcd_pkg::S_C_W3:    state_d = pcd_pkg::S_C_Q;
      pcd_pkg::S_C_Q:     state_d = pcd_pkg::S_C_WR;
      pcd_pkg::S_C_WR: begin
        if (c_q != p_last) begin
          state_d = pcd_pkg::S_C_W3;
        end else if (b_q != p_last || a_q != p_last) begin
          state_d = pcd_pkg::S_C_ZY;
        end else begin
          state_d = pcd_pkg::S_IDLE;
        end
      end
      pcd_pkg::S_RD:      state_d = pcd_pkg::S_RD_OUT;
      pcd_pkg::S_RD_OUT:  if (!out_valid_q || out_ready_i) state_d = pcd_pkg::S_IDLE;
      default:            state_d = pcd_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- unit controls
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    grid_req = '0;
    case (state_q)
      pcd_pkg::S_CLEAR: begin
        grid_req.we    = 1'b1;
        grid_req.waddr = clr_q;
      end
      pcd_pkg::S_IDLE: begin
        grid_req.we    = in_acc && (pcd_pkg::op_e'(op_i) == pcd_pkg::OP_WRITE);
        grid_req.waddr = {cell_z_i, cell_y_i, cell_x_i};
        grid_req.wdata = cell_value_i;
      end
      pcd_pkg::S_AX_MUL: begin
        mul_a = pos_q[axis_q];
        mul_b = {8'd0, inv_q[axis_q]};
      end
      pcd_pkg::S_AX_PW: begin
        mul_a = {2'b00, (k_q == 3'd2) ? ax_q : pw_q[k_q - 3'd1]};
        mul_b = {2'b00, ax_q};
      end
      pcd_pkg::S_AX_DIV: begin
        mul_a = q40[31:0];
        mul_b = pcd_pkg::RECIP3;
      end
      pcd_pkg::S_C_ZY: begin
        mul_a = {1'b0, w_q[0][a_q]};
        mul_b = {1'b0, w_q[1][b_q]};
      end
      pcd_pkg::S_C_W3: begin
        mul_a = {1'b0, wzy_q};
        mul_b = {1'b0, w_q[2][c_q]};
        grid_req.re    = 1'b1;
        grid_req.raddr = cell_a;
      end
      pcd_pkg::S_C_Q: begin
        mul_a = q_mag_q;
        mul_b = mul_p[61:30];
      end
      pcd_pkg::S_C_WR: begin
        grid_req.we    = 1'b1;
        grid_req.waddr = addr_q;
        grid_req.wdata = sum_sat;
      end
      pcd_pkg::S_RD: begin
        grid_req.re    = 1'b1;
        grid_req.raddr = addr_q;
      end
      default: ;
    endcase
  end

  pcd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pcd_grid u_grid (
    .clk_i   (clk_i),
    .req_i   (grid_req),
    .rdata_o (grid_rd)
  );

  // ---------------------------------------------------------------- control regs
  logic out_load;
  assign out_load = (state_q == pcd_pkg::S_RD_OUT) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcd_pkg::S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == pcd_pkg::S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= grid_rd;
    end
    case (state_q)
      pcd_pkg::S_IDLE: begin
        if (in_acc) begin
          pos_q   <= '{pos_z_i, pos_y_i, pos_x_i};
          q_neg_q <= charge_i[31];
          q_mag_q <= charge_i[31] ? 32'(-charge_i) : charge_i;
          axis_q  <= 2'd0;
          j_q     <= 3'd0;
          addr_q  <= {cell_z_i, cell_y_i, cell_x_i};
        end
      end
      pcd_pkg::S_AX_BASE: begin
        base_q  <= s_val[55:32];
        x_neg_q <= x_val[31];
        ax_q    <= ax_val;
        rem_q   <= 5'd0;
        cnt_q   <= 5'd23;
      end
      pcd_pkg::S_AX_MOD: begin
        rem_q  <= rem_n;
        base_q <= base_q << 1;
        cnt_q  <= cnt_q - 5'd1;
        k_q    <= 3'd2;
      end
      pcd_pkg::S_AX_PW: begin
        if (k_q == 3'd2) begin
          idx_q[axis_q] <= idx_n;
        end
      end
      pcd_pkg::S_AX_PWW: begin
        pw_q[k_q] <= mul_p[59:30];
        if (k_q == 3'd4) begin
          k_q   <= 3'd0;
          j_q   <= 3'd0;
          num_q <= '0;
        end else begin
          k_q <= k_q + 3'd1;
        end
      end
      pcd_pkg::S_AX_NUM: begin
        num_q <= num_d;
        k_q   <= k_q + 3'd1;
      end
      pcd_pkg::S_AX_WT: begin
        w_q[axis_q][j_q] <= w_fin;
        k_q   <= 3'd0;
        num_q <= '0;
        if (j_q == p_last) begin
          j_q    <= 3'd0;
          axis_q <= axis_q + 2'd1;
          a_q    <= 3'd0;
          b_q    <= 3'd0;
          c_q    <= 3'd0;
        end else begin
          j_q <= j_q + 3'd1;
        end
      end
      pcd_pkg::S_C_ZYW: wzy_q <= mul_p[60:30];
      pcd_pkg::S_C_W3:  addr_q <= cell_a;
      pcd_pkg::S_C_WR: begin
        if (c_q != p_last) begin
          c_q <= c_q + 3'd1;
        end else begin
          c_q <= 3'd0;
          if (b_q != p_last) begin
            b_q <= b_q + 3'd1;
          end else begin
            b_q <= 3'd0;
            a_q <= a_q + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign cell_value_out_o = out_q;

  // ---------------------------------------------------------------- checks
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcd_pkg::S_CLEAR) |-> !in_ready_o)
    else $error("input taken during clearing pass");

  a_cell_loop_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcd_pkg::S_C_WR) |-> (a_q <= p_last && b_q <= p_last && c_q <= p_last))
    else $error("cell loop counter past order");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcd_pkg::S_C_ZY) |-> (w_q[0][a_q] <= pcd_pkg::W_ONE &&
                                      w_q[1][b_q] <= pcd_pkg::W_ONE))
    else $error("weight above one");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pcd_pkg::S_RD) |=> (state_q == pcd_pkg::S_RD_OUT))
    else $error("read did not reach output stage");

endmodule

`default_nettype wire

FILE: tb/pcd_checker.sv
// Scoreboard for the charge deposition core: grid predictor and read-result compare.
`timescale 1ns / 1ps
`default_nettype none

module pcd_checker
  import pcd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [1:0]         op_i,
  input  wire logic [31:0]        pos_z_i,
  input  wire logic [31:0]        pos_y_i,
  input  wire logic [31:0]        pos_x_i,
  input  wire logic signed [31:0] charge_i,
  input  wire logic [3:0]         cell_z_i,
  input  wire logic [3:0]         cell_y_i,
  input  wire logic [3:0]         cell_x_i,
  input  wire logic signed [47:0] cell_value_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [47:0] cell_value_out_i,
  output int                      errors_o,
  output int                      pending_o
);

  localparam longint CELL_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint CELL_LO = -CELL_HI - 1;
  localparam longint Q30     = 64'sd1 << 30;

  longint            grid_m [CELLS];
  logic [47:0]       read_vals_q [$];
  logic [2:0]        order_m;
  logic [4:0]        dz_m, dy_m, dx_m;
  logic [23:0]       invz_m, invy_m, invx_m;
  logic [47:0]       want;

  function automatic longint coef(int p, int j, int k);
    logic [39:0] row;
    case ({p[1:0], j[2:0]})
      {2'd0, 3'd0}: row = {8'd1, -8'd1, 8'd0, 8'd0, 8'd0};
      {2'd0, 3'd1}: row = {8'd0, 8'd1, 8'd0, 8'd0, 8'd0};
      {2'd1, 3'd0}: row = {8'd1, -8'd4, 8'd4, 8'd0, 8'd0};
      {2'd1, 3'd1}: row = {8'd3, 8'd0, -8'd4, 8'd0, 8'd0};
      {2'd1, 3'd2}: row = {8'd1, 8'd4, 8'd4, 8'd0, 8'd0};
      {2'd2, 3'd0}: row = {8'd1, -8'd6, 8'd12, -8'd8, 8'd0};
      {2'd2, 3'd1}: row = {8'd23, -8'd30, -8'd12, 8'd24, 8'd0};
      {2'd2, 3'd2}: row = {8'd23, 8'd30, -8'd12, -8'd24, 8'd0};
      {2'd2, 3'd3}: row = {8'd1, 8'd6, 8'd12, 8'd8, 8'd0};
      {2'd3, 3'd0}: row = {8'd1, -8'd8, 8'd24, -8'd32, 8'd16};
      {2'd3, 3'd1}: row = {8'd19, -8'd44, 8'd24, 8'd16, -8'd16};
      {2'd3, 3'd2}: row = {8'd115, 8'd0, -8'd120, 8'd0, 8'd48};
      {2'd3, 3'd3}: row = {8'd19, 8'd44, 8'd24, -8'd16, -8'd16};
      {2'd3, 3'd4}: row = {8'd1, 8'd8, 8'd24, 8'd32, 8'd16};
      default:      row = '0;
    endcase
    return longint'($signed(row[8*(4-k) +: 8]));
  endfunction

  function automatic longint denom(int p, int j);
    case (p)
      1:       return (j == 1) ? 4 : 8;
      2:       return 48;
      3:       return (j == 0 || j == 4) ? 384 : ((j == 2) ? 192 : 96);
      default: return 1;
    endcase
  endfunction

  // Per-axis wrapped indices and spline weights (Q2.30).
  function automatic void axis(input logic [31:0] pos, input logic [23:0] inv,
                               input int unsigned dim, input int unsigned pts,
                               output int unsigned idx [5],
                               output longint unsigned wt [5]);
    longint unsigned s, base;
    longint unsigned pw [5];
    longint          x, ax, num, term;
    int unsigned     half;
    half = (pts - 1) / 2;
    s = longint'(pos) * longint'(inv);
    if (pts[0]) s += 64'd1 << 31;
    base = s >> 32;
    x = longint'(s[31:0] >> 2);
    if (pts != 2) x -= Q30 / 2;
    ax = (x < 0) ? -x : x;
    pw[0] = Q30;
    for (int k = 1; k < 5; k++) pw[k] = (pw[k-1] * ax) >> 30;
    for (int j = 0; j < 5; j++) begin
      idx[j] = 0;
      wt[j]  = 0;
    end
    for (int j = 0; j < pts; j++) begin
      num = 0;
      for (int k = 0; k < 5; k++) begin
        term = longint'(pw[k]);
        if (x < 0 && k[0]) term = -term;
        num += coef(pts - 2, j, k) * term;
      end
      num = num / denom(pts - 2, j);
      if (num < 0) num = 0;
      if (num > Q30) num = Q30;
      wt[j]  = num;
      idx[j] = ((base % dim) + dim - half + j) % dim;
    end
  endfunction

  function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void deposit(logic [31:0] pz, logic [31:0] py, logic [31:0] px,
                                  logic [31:0] q);
    int unsigned     pts, iz [5], iy [5], ix [5], adr;
    longint unsigned wz [5], wy [5], wx [5], qmag, wzy, w3;
    longint          add, sum;
    logic            neg;
    pts  = clampu(order_m, 2, MAX_ORDER);
    neg  = q[31];
    qmag = neg ? (64'd1 << 32) - q : q;
    axis(pz, invz_m, clampu(dz_m, 2, MAX_DIM), pts, iz, wz);
    axis(py, invy_m, clampu(dy_m, 2, MAX_DIM), pts, iy, wy);
    axis(px, invx_m, clampu(dx_m, 2, MAX_DIM), pts, ix, wx);
    for (int a = 0; a < pts; a++)
      for (int b = 0; b < pts; b++) begin
        wzy = (wz[a] * wy[b]) >> 30;
        for (int c = 0; c < pts; c++) begin
          w3  = (wzy * wx[c]) >> 30;
          add = longint'((qmag * w3) >> 30);
          if (neg) add = -add;
          adr = (iz[a] * MAX_DIM + iy[b]) * MAX_DIM + ix[c];
          sum = grid_m[adr] + add;
          if (sum > CELL_HI) sum = CELL_HI;
          if (sum < CELL_LO) sum = CELL_LO;
          grid_m[adr] = sum;
        end
      end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) grid_m[i] = 0;
      order_m = 3'd2;
      dz_m = 5'd16; dy_m = 5'd16; dx_m = 5'd16;
      invz_m = 24'd65536; invy_m = 24'd65536; invx_m = 24'd65536;
      read_vals_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ORDER: order_m = cfg_data_i[2:0];
          CFG_DIM_Z: dz_m    = cfg_data_i[4:0];
          CFG_DIM_Y: dy_m    = cfg_data_i[4:0];
          CFG_DIM_X: dx_m    = cfg_data_i[4:0];
          CFG_INV_Z: invz_m  = cfg_data_i;
          CFG_INV_Y: invy_m  = cfg_data_i;
          CFG_INV_X: invx_m  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (read_vals_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result beat, value %h", $time, cell_value_out_i);
        end else begin
          want = read_vals_q.pop_front();
          if (cell_value_out_i !== want) begin
            errors_o++;
            $display("%0t: cell_value_out mismatch: expected %h actual %h",
                     $time, want, cell_value_out_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (op_e'(op_i))
          OP_DEPOSIT: deposit(pos_z_i, pos_y_i, pos_x_i, charge_i);
          OP_READ: read_vals_q.push_back(
                     grid_m[{cell_z_i, cell_y_i, cell_x_i}][47:0]);
          OP_WRITE: grid_m[{cell_z_i, cell_y_i, cell_x_i}] = longint'(cell_value_i);
          default: ;
        endcase
      end
      pending_o = read_vals_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/particle_charge_deposition_core_tb.sv
// Testbench top for the charge deposition core: stimulus, flow control and verdict.
`timescale 1ns / 1ps
`default_nettype none

module particle_charge_deposition_core_tb;
  import pcd_pkg::*;

  logic               clk, rst_n;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_data;
  logic               in_valid, in_ready;
  logic [1:0]         op;
  logic [31:0]        pos_z, pos_y, pos_x;
  logic signed [31:0] charge;
  logic [3:0]         cell_z, cell_y, cell_x;
  logic signed [47:0] cell_value;
  logic               out_valid, out_ready;
  logic signed [47:0] cell_value_out;
  int                 errors, pending;
  // quiet: no idling on either side (tail of the run)
  // hold_req: ask the result side for one long stall
  logic               quiet, hold_req;

  // Drain time before a register write, long enough for the longest deposit (order 5).
  localparam int DRAIN = 700;
  localparam int PHASES = 8;
  localparam int PER_PHASE = 140;

  particle_charge_deposition_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .op_i            (op),
    .pos_z_i         (pos_z),
    .pos_y_i         (pos_y),
    .pos_x_i         (pos_x),
    .charge_i        (charge),
    .cell_z_i        (cell_z),
    .cell_y_i        (cell_y),
    .cell_x_i        (cell_x),
    .cell_value_i    (cell_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .cell_value_out_o(cell_value_out)
  );

  pcd_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .op_i            (op),
    .pos_z_i         (pos_z),
    .pos_y_i         (pos_y),
    .pos_x_i         (pos_x),
    .charge_i        (charge),
    .cell_z_i        (cell_z),
    .cell_y_i        (cell_y),
    .cell_x_i        (cell_x),
    .cell_value_i    (cell_value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .cell_value_out_i(cell_value_out),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit: worst case is far below this even with every deposit at order 5.
  initial begin
    #60ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One beat on the item channel; valid stays up into the next call unless a gap follows.
  task automatic send(logic [1:0] o, logic [31:0] pz, logic [31:0] py, logic [31:0] px,
                      logic [31:0] q, logic [3:0] cz, logic [3:0] cy, logic [3:0] cx,
                      logic [47:0] v);
    in_valid   <= 1'b1;
    op         <= o;
    pos_z      <= pz;
    pos_y      <= py;
    pos_x      <= px;
    charge     <= q;
    cell_z     <= cz;
    cell_y     <= cy;
    cell_x     <= cx;
    cell_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Wait for every read result, then let a trailing deposit finish.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Write all register indexes in one burst, including the unused one.
  task automatic write_regs(logic [23:0] vals [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pos();
    return ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 32'h0014_0000);
  endfunction

  function automatic logic [31:0] rand_charge();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [47:0] rand_cell();
    case ($urandom_range(0, 3))
      0:       return {$urandom(), $urandom()};
      1:       return {1'b0, {47{1'b1}}} - $urandom_range(0, 32'h0010_0000);
      2:       return {1'b1, 47'd0} + $urandom_range(0, 32'h0010_0000);
      default: return 48'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endcase
  endfunction

  task automatic rand_item();
    int sel;
    sel = $urandom_range(0, 99);
    send((sel < 35) ? OP_DEPOSIT : (sel < 70) ? OP_READ : (sel < 95) ? OP_WRITE : OP_NONE,
         rand_pos(), rand_pos(), rand_pos(), rand_charge(),
         $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
         rand_cell());
  endtask

  logic [23:0] regs [8];
  // Register sets per phase: order, dim z/y/x, inverse spacing z/y/x, unused index.
  logic [23:0] phase_regs [PHASES][8] = '{
    '{24'd5, 24'd16, 24'd16, 24'd16, 24'h01_0000, 24'h01_0000, 24'h01_0000, 24'hFF_FFFF},
    '{24'd3, 24'd2,  24'd2,  24'd2,  24'hFF_FFFF, 24'h00_8000, 24'h00_0001, 24'd0},
    '{24'd4, 24'd7,  24'd11, 24'd5,  24'h02_4000, 24'h00_C000, 24'h01_8000, 24'd0},
    '{24'd0, 24'd0,  24'd31, 24'd1,  24'd0,       24'd0,       24'd0,       24'd0},
    '{24'd7, 24'd3,  24'd16, 24'd9,  24'h01_0000, 24'd0,       24'hAB_CDEF, 24'd0},
    '{24'd2, 24'd16, 24'd2,  24'd16, 24'h55_5555, 24'h01_0000, 24'h00_4000, 24'd0},
    '{24'd5, 24'd6,  24'd6,  24'd13, 24'h00_2000, 24'h12_3456, 24'h01_0000, 24'd0},
    '{24'd2, 24'd16, 24'd16, 24'd16, 24'h01_0000, 24'h01_0000, 24'h01_0000, 24'd0}
  };

  initial begin
    rst_n = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; op = OP_NONE;
    pos_z = '0; pos_y = '0; pos_x = '0; charge = '0;
    cell_z = '0; cell_y = '0; cell_x = '0; cell_value = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings (order 2, full grid, unit spacing).
    send(OP_READ,  0, 0, 0, 0, 4'd0, 4'd0, 4'd0, 0);
    send(OP_WRITE, 0, 0, 0, 0, 4'd15, 4'd15, 4'd15, {1'b0, {47{1'b1}}});
    send(OP_WRITE, 0, 0, 0, 0, 4'd0, 4'd0, 4'd0, {1'b1, 47'd0});
    send(OP_READ,  0, 0, 0, 0, 4'd15, 4'd15, 4'd15, 0);
    send(OP_READ,  0, 0, 0, 0, 4'd0, 4'd0, 4'd0, 0);
    // saturation both ways on the extreme cells
    send(OP_DEPOSIT, 32'h000F_0000, 32'h000F_0000, 32'h000F_0000, 32'h7FFF_FFFF,
         0, 0, 0, 0);
    send(OP_DEPOSIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000,
         0, 0, 0, 0);
    send(OP_READ,  0, 0, 0, 0, 4'd15, 4'd15, 4'd15, 0);
    send(OP_READ,  0, 0, 0, 0, 4'd0, 4'd0, 4'd0, 0);
    // positions at the top of the range wrap around the grid
    send(OP_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000,
         0, 0, 0, 0);
    send(OP_DEPOSIT, 32'h0001_8000, 32'h0002_4000, 32'h0003_C000, 32'hFFFF_0000,
         0, 0, 0, 0);
    send(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         4'd15, 4'd15, 4'd15, {48{1'b1}});
    send(OP_READ,  0, 0, 0, 0, 4'd15, 4'd15, 4'd15, 0);
    send(OP_READ,  0, 0, 0, 0, 4'd1, 4'd2, 4'd3, 0);
    send(OP_READ,  0, 0, 0, 0, 4'd1, 4'd1, 4'd1, 0);
    send(OP_WRITE, 0, 0, 0, 0, 4'd5, 4'd10, 4'd3, 48'h0000_0001_0000);
    send(OP_READ,  0, 0, 0, 0, 4'd5, 4'd10, 4'd3, 0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      regs = phase_regs[ph];
      write_regs(regs);
      quiet = (ph == PHASES - 1);
      for (int n = 0; n < PER_PHASE; n++) begin
        // long result stall with the sender still pushing reads
        if (ph == 2 && n == 20) begin
          hold_req = 1'b1;
          for (int r = 0; r < 12; r++)
            send(OP_READ, 0, 0, 0, 0, $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(0, 15), 0);
        end
        // sender pauses until all read results are back
        if (n == PER_PHASE / 2) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        rand_item();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
design/pcd_pkg.sv
design/pcd_mul.sv
design/pcd_grid.sv
design/particle_charge_deposition_core.sv
tb/pcd_checker.sv
tb/particle_charge_deposition_core_tb.sv
